// File: hdl/bmpdec_pkg.sv
// ----------------------------------------------------------------------------
// bmpdec_pkg
// shared constants, codes and result type of the 24-bit bmp stream decoder
// ----------------------------------------------------------------------------
package bmpdec_pkg;

	// width of the delivered pixel counter
	localparam int COUNT_BITS = 32;

	// header layout, byte positions in the file
	localparam int HDR_LEN    = 54;
	localparam int OFS_DATA   = 10;
	localparam int OFS_WIDTH  = 18;
	localparam int OFS_HEIGHT = 22;
	localparam int OFS_SIZE   = 34;

	localparam logic [7:0] MAGIC_B = 8'h42;
	localparam logic [7:0] MAGIC_M = 8'h4D;

	// result queue
	localparam int FIFO_DEPTH = 8;
	localparam int FIFO_AW    = 3;

	typedef logic [COUNT_BITS-1:0] count_t;

	typedef enum logic [1:0] {
		PH_HEADER = 2'd0,
		PH_DATA   = 2'd1,
		PH_FAILED = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		KIND_HEADER = 2'd0,
		KIND_PIXEL  = 2'd1,
		KIND_DONE   = 2'd2,
		KIND_ERROR  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_SHORT     = 2'd1,
		ST_BAD_MAGIC = 2'd2,
		ST_TRUNC     = 2'd3
	} status_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [15:0] width;
		logic [15:0] height;
		status_t     status;
		logic        eor;
	} result_t;

endpackage

// File: hdl/bmp_header_parse_bgr_to_rgba.sv
// ----------------------------------------------------------------------------
// bmp_header_parse_bgr_to_rgba
// 24-bit bmp byte stream decoder: header capture and check, then bgr triples
// turned into rgba pixels with zero alpha, with a finished or error status
// ----------------------------------------------------------------------------
//
// channel  dir  beats                      payload
// s_*      in   one file byte per item     tdata = data_byte, tlast = last_byte
// m_*      out  0..2 results per byte      tuser = kind, tdata = pixel/header
//                                          fields, tlast = end_of_run
//
// one byte per cycle while s_tready is high; an accepted byte is registered in the
// input register, and its results are written from there into an 8-entry
// result queue, whose head drives the m_* outputs
// s_tready drops only while the result queue lacks room for two more results
// behind the byte in flight, i.e. when m_tready has been low for a while
// reset (arst_n low) returns the parser to the start of a file and empties
// the queue; after any last byte the parser also restarts on its own
//
module bmp_header_parse_bgr_to_rgba (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tlast,   // last_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	// [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha,
	// [47:32] image_width, [63:48] image_height, [65:64] status, [71:66] zero
	output logic [71:0] m_tdata,
	output logic [1:0]  m_tuser,   // [1:0] kind
	output logic        m_tlast    // end_of_run
);

	// input register
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;

	// parser state
	bmpdec_pkg::phase_t phase_q, phase_mid, phase_d;
	logic [31:0] boff_q;
	logic        magic_ok_q;
	logic [31:0] data_off_q;
	logic [31:0] size_q;
	logic [15:0] width_q;
	logic [15:0] height_q;
	logic [31:0] prod_q;       // width * height, settles long before header end
	logic [7:0]  held0_q;
	logic [7:0]  held1_q;
	logic [1:0]  tpos_q;
	bmpdec_pkg::count_t pix_q;

	// result queue
	bmpdec_pkg::result_t fifo_q [bmpdec_pkg::FIFO_DEPTH];
	logic [bmpdec_pkg::FIFO_AW-1:0] head_q, tail_q;
	logic [bmpdec_pkg::FIFO_AW:0]   count_q;

	// datapath
	logic [31:0] start_c;
	logic [31:0] size_fill;
	logic [31:0] size_eff;
	logic [32:0] len_c;
	logic [32:0] end_c;
	bmpdec_pkg::count_t wanted;
	bmpdec_pkg::count_t pix_next;
	logic        at_hdr_end;
	logic        take;
	logic        pixel;
	logic        trunc;

	bmpdec_pkg::result_t res_a, res_b, r0, r1;
	logic        has_a, has_b;
	logic [1:0]  n_push;
	logic        pop;

	// ---------------- input side ----------------

	// room for two results of the byte in flight and two of the new one
	assign s_tready = (count_q + (valid_s1 ? 4'd2 : 4'd0)) <= 4'(bmpdec_pkg::FIFO_DEPTH - 2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= s_tvalid & s_tready;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	// ---------------- parser datapath ----------------

	// offsets below the header end count as the header end
	assign start_c   = (data_off_q < 32'(bmpdec_pkg::HDR_LEN)) ?
		32'(bmpdec_pkg::HDR_LEN) : data_off_q;
	assign size_fill = prod_q + {prod_q[30:0], 1'b0};
	// a last byte at header end sees the filled-in size
	assign size_eff  = (phase_q == bmpdec_pkg::PH_HEADER && size_q == 32'd0) ?
		size_fill : size_q;
	assign wanted    = bmpdec_pkg::count_t'(prod_q);
	assign at_hdr_end = (boff_q == 32'(bmpdec_pkg::HDR_LEN - 1));

	assign take  = (phase_q == bmpdec_pkg::PH_DATA) && (boff_q >= start_c) &&
		(pix_q != wanted);
	assign pixel = take && (tpos_q == 2'd2);
	assign pix_next = pix_q + bmpdec_pkg::count_t'(pixel);

	// file length vs. start + size covers both offset beyond file and short data
	assign len_c = {1'b0, boff_q} + 33'd1;
	assign end_c = {1'b0, start_c} + {1'b0, size_eff};
	assign trunc = (len_c < end_c) || (pix_next != wanted);

	// next phase
	always_comb begin
		phase_mid = phase_q;
		if (valid_s1 && phase_q == bmpdec_pkg::PH_HEADER) begin
			if (at_hdr_end) begin
				phase_mid = magic_ok_q ? bmpdec_pkg::PH_DATA : bmpdec_pkg::PH_FAILED;
			end else if (last_s1) begin
				phase_mid = bmpdec_pkg::PH_FAILED;
			end
		end
		phase_d = (valid_s1 && last_s1) ? bmpdec_pkg::PH_HEADER : phase_mid;
	end

	// results of the byte in the input register
	always_comb begin
		res_a = '0;
		res_b = '0;
		has_a = 1'b0;
		has_b = 1'b0;
		res_b.kind = bmpdec_pkg::KIND_DONE;
		res_b.eor  = 1'b1;
		if (valid_s1) begin
			unique case (phase_q)
				bmpdec_pkg::PH_HEADER: begin
					if (at_hdr_end) begin
						has_a = 1'b1;
						if (!magic_ok_q) begin
							res_a.kind   = bmpdec_pkg::KIND_ERROR;
							res_a.status = bmpdec_pkg::ST_BAD_MAGIC;
						end else begin
							res_a.kind   = bmpdec_pkg::KIND_HEADER;
							res_a.width  = width_q;
							res_a.height = height_q;
						end
					end else if (last_s1) begin
						has_a = 1'b1;
						res_a.kind   = bmpdec_pkg::KIND_ERROR;
						res_a.status = bmpdec_pkg::ST_SHORT;
					end
				end
				bmpdec_pkg::PH_DATA: begin
					if (pixel) begin
						has_a = 1'b1;
						res_a.kind  = bmpdec_pkg::KIND_PIXEL;
						res_a.red   = byte_s1;
						res_a.green = held1_q;
						res_a.blue  = held0_q;
					end
				end
				default: begin
				end
			endcase
			if (last_s1 && phase_mid == bmpdec_pkg::PH_DATA) begin
				has_b = 1'b1;
				if (trunc) begin
					res_b.kind   = bmpdec_pkg::KIND_ERROR;
					res_b.status = bmpdec_pkg::ST_TRUNC;
				end
			end
		end
		res_a.eor = !has_b;
		r0     = has_a ? res_a : res_b;
		r1     = res_b;
		n_push = {1'b0, has_a} + {1'b0, has_b};
	end

	// parser registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= bmpdec_pkg::PH_HEADER;
			boff_q     <= '0;
			magic_ok_q <= 1'b1;
			data_off_q <= '0;
			size_q     <= '0;
			width_q    <= '0;
			height_q   <= '0;
			prod_q     <= '0;
			held0_q    <= '0;
			held1_q    <= '0;
			tpos_q     <= '0;
			pix_q      <= '0;
		end else begin
			prod_q  <= 32'(width_q) * 32'(height_q);
			phase_q <= phase_d;
			if (valid_s1) begin
				if (last_s1) begin
					// next byte starts a new file
					boff_q     <= '0;
					magic_ok_q <= 1'b1;
					data_off_q <= '0;
					size_q     <= '0;
					width_q    <= '0;
					height_q   <= '0;
					held0_q    <= '0;
					held1_q    <= '0;
					tpos_q     <= '0;
					pix_q      <= '0;
				end else begin
					if (boff_q != 32'hFFFF_FFFF) begin
						boff_q <= boff_q + 32'd1;
					end
					if (phase_q == bmpdec_pkg::PH_HEADER) begin
						if (boff_q == 32'd0 && byte_s1 != bmpdec_pkg::MAGIC_B) begin
							magic_ok_q <= 1'b0;
						end
						if (boff_q == 32'd1 && byte_s1 != bmpdec_pkg::MAGIC_M) begin
							magic_ok_q <= 1'b0;
						end
						for (int k = 0; k < 4; k++) begin
							if (boff_q == 32'(bmpdec_pkg::OFS_DATA + k)) begin
								data_off_q[8*k +: 8] <= byte_s1;
							end
							if (boff_q == 32'(bmpdec_pkg::OFS_SIZE + k)) begin
								size_q[8*k +: 8] <= byte_s1;
							end
						end
						for (int k = 0; k < 2; k++) begin
							if (boff_q == 32'(bmpdec_pkg::OFS_WIDTH + k)) begin
								width_q[8*k +: 8] <= byte_s1;
							end
							if (boff_q == 32'(bmpdec_pkg::OFS_HEIGHT + k)) begin
								height_q[8*k +: 8] <= byte_s1;
							end
						end
						if (at_hdr_end && magic_ok_q) begin
							size_q <= size_eff;
						end
					end
					if (take) begin
						unique case (tpos_q)
							2'd0: begin
								held0_q <= byte_s1;
								tpos_q  <= 2'd1;
							end
							2'd1: begin
								held1_q <= byte_s1;
								tpos_q  <= 2'd2;
							end
							default: begin
								tpos_q <= 2'd0;
							end
						endcase
					end
					pix_q <= pix_next;
				end
			end
		end
	end

	// ---------------- result queue ----------------

	assign pop      = m_tvalid & m_tready;
	assign m_tvalid = (count_q != '0);
	assign m_tuser  = fifo_q[head_q].kind;
	assign m_tlast  = fifo_q[head_q].eor;
	assign m_tdata  = {6'd0, fifo_q[head_q].status, fifo_q[head_q].height,
		fifo_q[head_q].width, 8'd0, fifo_q[head_q].blue, fifo_q[head_q].green,
		fifo_q[head_q].red};

	always_ff @(posedge clk) begin
		if (n_push != 2'd0) begin
			fifo_q[tail_q] <= r0;
		end
		if (n_push == 2'd2) begin
			fifo_q[tail_q + 3'd1] <= r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (pop) begin
				head_q <= head_q + 3'd1;
			end
			tail_q  <= tail_q + 3'(n_push);
			count_q <= count_q + 4'(n_push) - 4'(pop);
		end
	end

	// ---------------- checks ----------------

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 4'(bmpdec_pkg::FIFO_DEPTH))
		else $error("result queue count out of range");

	a_room_for_byte: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> count_q <= 4'(bmpdec_pkg::FIFO_DEPTH - 2))
		else $error("no room for results of byte in flight");

	a_pixel_in_data: assert property (@(posedge clk) disable iff (!arst_n)
		(has_a && res_a.kind == bmpdec_pkg::KIND_PIXEL) |->
			phase_q == bmpdec_pkg::PH_DATA)
		else $error("pixel outside data phase");

	a_triple_pos: assert property (@(posedge clk) disable iff (!arst_n)
		tpos_q != 2'd3)
		else $error("triple position out of range");

	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && last_s1) |=> (boff_q == 32'd0 && phase_q == bmpdec_pkg::PH_HEADER))
		else $error("parser did not restart after last byte");

endmodule
